// ----- src/crfo_pkg.sv -----
// Shared types, constants and helpers for the circle raster framebuffer.
// No dependencies; compiled before the interfaces and the top level.
package crfo_pkg;

    // Frame geometry and store layout
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int PIX_DEPTH  = 1 << ADDR_W;

    // Field widths
    localparam int DIM_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 20;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;

    // Fixed point arithmetic
    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int ONE_SQ    = ONE * ONE;
    localparam int D_W       = COORD_W + 2;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 1;
    localparam int ACC_W     = SQ_W + 2;

    // Shape bytes
    localparam logic [BYTE_W-1:0] SHAPE_OUTLINE = 8'h63;
    localparam logic [BYTE_W-1:0] SHAPE_FILLED  = 8'h43;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BACKGROUND   = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_REJECT    = 2'd1,
        STAT_BAD_FRAME = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_DONE
    } t_state;

    // Magnitude of a signed coordinate; the most negative value maps to 2^(COORD_W-1)
    function automatic logic [COORD_W-1:0] mag(logic signed [COORD_W-1:0] v);
        logic [COORD_W-1:0] res;
        res = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
        return res;
    endfunction

    // Last column in use, with the register saturated into 1..MAX_WIDTH
    function automatic logic [COL_W-1:0] col_last(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] dec;
        logic [COL_W-1:0] res;
        dec = v - DIM_W'(1);
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_W'(MAX_WIDTH)) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = dec[COL_W-1:0];
        end
        return res;
    endfunction

    // Last row in use, with the register saturated into 1..MAX_HEIGHT
    function automatic logic [ROW_W-1:0] row_last(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] dec;
        logic [ROW_W-1:0] res;
        dec = v - DIM_W'(1);
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_W'(MAX_HEIGHT)) begin
            res = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            res = dec[ROW_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- src/crfo_if.sv -----
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on crfo_pkg for field widths.
interface crfo_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [crfo_pkg::REQ_W-1:0]           req_type;
    logic [crfo_pkg::BYTE_W-1:0]          shape_char;
    logic signed [crfo_pkg::COORD_W-1:0]  center_x;
    logic signed [crfo_pkg::COORD_W-1:0]  center_y;
    logic signed [crfo_pkg::COORD_W-1:0]  circle_radius;
    logic [crfo_pkg::BYTE_W-1:0]          paint_byte;
    logic [crfo_pkg::BYTE_W-1:0]          read_col;
    logic [crfo_pkg::BYTE_W-1:0]          read_row;

    modport source (
        output valid, req_type, shape_char, center_x, center_y, circle_radius,
               paint_byte, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, req_type, shape_char, center_x, center_y, circle_radius,
               paint_byte, read_col, read_row,
        output ready
    );
endinterface

interface crfo_res_if;
    logic                          valid;
    logic                          ready;
    logic [crfo_pkg::STAT_W-1:0]   status;
    logic [crfo_pkg::BYTE_W-1:0]   pixel_value;

    modport source (output valid, status, pixel_value, input ready);
    modport sink   (input  valid, status, pixel_value, output ready);
endinterface

interface crfo_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [crfo_pkg::CIDX_W-1:0]   wr_index;
    logic [crfo_pkg::DIM_W-1:0]    wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input  valid, wr_index, wr_data, output ready);
endinterface

// ----- src/circle_raster_fill_outline.sv -----
// Byte framebuffer with clear, circle draw (filled or outline) and pixel read.
// Depends on crfo_pkg and the channel interfaces in crfo_if.sv.
//
// Usage: requests enter on i_req (valid/ready), one result per request leaves
// on o_res, and i_cfg writes frame_width, frame_height and background_byte
// (index 0, 1, 2; other indexes are ignored). i_cfg is always ready.
// The block works on one request at a time; i_req.ready is high only when
// the sequencer is idle. Work per request, from acceptance to result:
//   clear         all PIX_DEPTH cells, one store write per cycle
//   good circle   four squarings on the shared multiplier,
//                 then one pixel per cycle through the distance adder
//   reject/ignore straight to the done state
//   read          the store read is registered
// The pixel sweep and the single write port of the store set how long these take.
// The result sits in an output register: the block takes the next request
// while a result waits, and holds a finished result in its done state only
// when the output register is still full. A stalled receiver therefore
// holds the block after at most one further request.
// Reset restores the registers to 256, 256, 0 and clears the error flag.
// The pixel store is not cleared at reset; issue a clear request first.
module circle_raster_fill_outline (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crfo_req_if.sink   i_req,
    crfo_res_if.source o_res,
    crfo_cfg_if.sink   i_cfg
);
    import crfo_pkg::*;

    // Configuration
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [BYTE_W-1:0] r_background;

    // Control
    t_state            r_state, n_state;
    logic              r_frame_bad;
    logic [1:0]        r_step;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [BYTE_W-1:0] r_out_pix;
    t_status           r_res_status;
    logic              r_rd_hit;

    // Circle parameters and sweep state
    logic signed [COORD_W-1:0] r_cx, r_cy, r_r;
    logic [COORD_W-1:0]        r_r1_mag;
    logic                      r_r1_neg;
    logic                      r_filled;
    logic [BYTE_W-1:0]         r_paint;
    logic [SQ_W-1:0]           r_r2, r_r12, r_cx2, r_dx2, r_dy2;
    logic signed [D_W-1:0]     r_dx, r_dy;
    logic [COL_W-1:0]          r_x;
    logic [ROW_W-1:0]          r_y;

    // Pixel store
    logic [BYTE_W-1:0] r_pixel_store [PIX_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Combinational control
    logic              req_acc;
    logic              out_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;
    logic              clear_last;
    logic              draw_last_col;
    logic              draw_last;

    // Datapath
    logic [COORD_W-1:0]        mul_a;
    logic [SQ_W-1:0]           mul_p;
    logic [D2_W-1:0]           d2;
    logic                      in_circle;
    logic                      rim;
    logic [ACC_W-1:0]          dx2_sum, dy2_sum;
    logic signed [D_W-1:0]     neg_cx, neg_cy;
    logic signed [COORD_W:0]   r1;
    logic                      bad_shape;
    logic                      rad_nonpos;

    assign w_last        = col_last(r_frame_width);
    assign h_last        = row_last(r_frame_height);
    assign req_acc       = i_req.valid && i_req.ready;
    assign clear_last    = (r_x == COL_W'(MAX_WIDTH - 1)) && (r_y == ROW_W'(MAX_HEIGHT - 1));
    assign draw_last_col = (r_x == w_last);
    assign draw_last     = draw_last_col && (r_y == h_last);

    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.pixel_value = r_out_pix;

    // Request decode
    assign bad_shape  = (i_req.shape_char != SHAPE_OUTLINE) &&
                        (i_req.shape_char != SHAPE_FILLED);
    assign rad_nonpos = i_req.circle_radius[COORD_W-1] || (i_req.circle_radius == '0);
    assign r1         = {i_req.circle_radius[COORD_W-1], i_req.circle_radius}
                        - (COORD_W+1)'(ONE);
    assign neg_cx     = -{{(D_W-COORD_W){r_cx[COORD_W-1]}}, r_cx};
    assign neg_cy     = -{{(D_W-COORD_W){r_cy[COORD_W-1]}}, r_cy};

    // Shared squaring unit, one operand per setup step
    always_comb begin
        case (r_step)
            2'd0:    mul_a = mag(r_r);
            2'd1:    mul_a = r_r1_mag;
            2'd2:    mul_a = mag(r_cx);
            default: mul_a = mag(r_cy);
        endcase
        mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);
    end

    // Distance test and incremental squares: (d + ONE)^2 = d^2 + 2*ONE*d + ONE^2
    always_comb begin
        d2        = {1'b0, r_dx2} + {1'b0, r_dy2};
        in_circle = (d2 <= {1'b0, r_r2});
        rim       = r_r1_neg || (d2 > {1'b0, r_r12});
        dx2_sum   = ACC_W'(r_dx2)
                  + ({{(ACC_W-D_W){r_dx[D_W-1]}}, r_dx} << (FRAC_BITS + 1))
                  + ACC_W'(ONE_SQ);
        dy2_sum   = ACC_W'(r_dy2)
                  + ({{(ACC_W-D_W){r_dy[D_W-1]}}, r_dy} << (FRAC_BITS + 1))
                  + ACC_W'(ONE_SQ);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    case (i_req.req_type)
                        REQ_CLEAR: n_state = ST_CLEAR;
                        REQ_DRAW: begin
                            if (r_frame_bad || rad_nonpos || bad_shape) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_SETUP;
                            end
                        end
                        REQ_READ: n_state = ST_READ;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clear_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SETUP: begin
                if (r_step == 2'd3) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (draw_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = r_background;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE:  i_req.ready = 1'b1;
            ST_CLEAR: mem_we = 1'b1;
            ST_DRAW: begin
                mem_we    = in_circle && (r_filled || rim);
                mem_wdata = r_paint;
            end
            ST_DONE:  out_load = !r_out_valid || o_res.ready;
            default:  mem_we = 1'b0;
        endcase
    end

    assign mem_waddr = {r_y, r_x};
    assign mem_raddr = {ROW_W'(i_req.read_row), COL_W'(i_req.read_col)};

    // Pixel store: one write port, registered read port; capture the read
    // at the accepting edge and hold it until the result is loaded
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pixel_store[mem_waddr] <= mem_wdata;
        end
        if (req_acc) begin
            r_rd_data <= r_pixel_store[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_bad    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_step         <= '0;
            r_frame_width  <= DIM_W'(MAX_WIDTH);
            r_frame_height <= DIM_W'(MAX_HEIGHT);
            r_background   <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.wr_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.wr_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.wr_data;
                    CFG_BACKGROUND:   r_background   <= i_cfg.wr_data[BYTE_W-1:0];
                    default:          r_background   <= r_background;
                endcase
            end

            if (req_acc && i_req.req_type == REQ_CLEAR) begin
                r_frame_bad <= 1'b0;
            end else if (req_acc && i_req.req_type == REQ_DRAW && !r_frame_bad &&
                         (rad_nonpos || bad_shape)) begin
                r_frame_bad <= 1'b1;
            end

            if (r_state == ST_SETUP) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= '0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_pix    <= (r_rd_hit) ? r_rd_data : '0;
        end

        case (r_state)
            ST_IDLE: begin
                r_x      <= '0;
                r_y      <= '0;
                r_rd_hit <= 1'b0;
                if (req_acc) begin
                    r_cx     <= i_req.center_x;
                    r_cy     <= i_req.center_y;
                    r_r      <= i_req.circle_radius;
                    r_paint  <= i_req.paint_byte;
                    r_filled <= (i_req.shape_char == SHAPE_FILLED);
                    r_r1_neg <= r1[COORD_W];
                    r_r1_mag <= (r1[COORD_W] || r1 == '0) ? '0 : r1[COORD_W-1:0];
                    r_rd_hit <= (i_req.req_type == REQ_READ) &&
                                (COL_W'(i_req.read_col) <= w_last) &&
                                (ROW_W'(i_req.read_row) <= h_last);
                    case (i_req.req_type)
                        REQ_CLEAR: r_res_status <= STAT_OK;
                        REQ_DRAW: begin
                            if (r_frame_bad) begin
                                r_res_status <= STAT_BAD_FRAME;
                            end else if (rad_nonpos || bad_shape) begin
                                r_res_status <= STAT_REJECT;
                            end else begin
                                r_res_status <= STAT_OK;
                            end
                        end
                        default: r_res_status <= r_frame_bad ? STAT_BAD_FRAME : STAT_OK;
                    endcase
                end
            end
            ST_CLEAR: begin
                r_x <= r_x + COL_W'(1);
                if (r_x == COL_W'(MAX_WIDTH - 1)) begin
                    r_y <= r_y + ROW_W'(1);
                end
            end
            ST_SETUP: begin
                r_dx <= neg_cx;
                r_dy <= neg_cy;
                case (r_step)
                    2'd0: r_r2  <= mul_p;
                    2'd1: r_r12 <= mul_p;
                    2'd2: begin
                        r_cx2 <= mul_p;
                        r_dx2 <= mul_p;
                    end
                    default: r_dy2 <= mul_p;
                endcase
            end
            ST_DRAW: begin
                if (draw_last_col) begin
                    // wrap to the next row
                    r_x   <= '0;
                    r_dx  <= neg_cx;
                    r_dx2 <= r_cx2;
                    r_y   <= r_y + ROW_W'(1);
                    r_dy  <= r_dy + D_W'(ONE);
                    r_dy2 <= dy2_sum[SQ_W-1:0];
                end else begin
                    r_x   <= r_x + COL_W'(1);
                    r_dx  <= r_dx + D_W'(ONE);
                    r_dx2 <= dx2_sum[SQ_W-1:0];
                end
            end
            default: r_x <= r_x;
        endcase
    end

    // Checks
    a_write_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR || r_state == ST_DRAW))
        else $error("store written outside a sweep");

    a_draw_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> (r_x <= w_last && r_y <= h_last))
        else $error("draw sweep left the active frame");

    a_clear_resets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.req_type == REQ_CLEAR) |=> !r_frame_bad)
        else $error("clear did not reset the error flag");

    a_bad_frame_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.req_type == REQ_DRAW && r_frame_bad)
        |=> (r_state == ST_DONE && r_res_status == STAT_BAD_FRAME))
        else $error("circle on bad frame was not skipped");

endmodule

// ----- tb/circle_raster_fill_outline_checker.sv -----
// Watches the request, result and register-write channels of the circle framebuffer.
// Keeps its own copy of the frame and predicts every result. Compares each one field by field.
// Depends on crfo_pkg and the channel interfaces in crfo_if.sv.
`timescale 1ns / 100ps

module circle_raster_fill_outline_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    crfo_req_if  i_req,
    crfo_res_if  i_res,
    crfo_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_drawn
);
    import crfo_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] pixel;
    } t_frame_answer;

    t_frame_answer     answers_q[$];
    logic [BYTE_W-1:0] pixels [PIX_DEPTH];
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [BYTE_W-1:0] bg_reg;
    bit                frame_bad;

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_errors++;
    endtask

    // Saturate a size register into 1..limit
    function automatic int unsigned used_dim(logic [DIM_W-1:0] v, int unsigned limit);
        if (v == '0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    // Distances are compared squared, in exact 64-bit arithmetic
    task automatic paint_circle(logic [BYTE_W-1:0] shape, longint cx, longint cy, longint rad,
                                logic [BYTE_W-1:0] paint, int unsigned w, int unsigned h);
        longint r1;
        longint r2;
        longint r12;
        longint dx;
        longint dy;
        longint d2;
        bit     in_circle;
        bit     rim;
        int     x;
        int     y;
        r1  = rad - ONE;
        r2  = rad * rad;
        r12 = (r1 > 0) ? r1 * r1 : 0;
        for (y = 0; y < h; y++) begin
            dy = longint'(y) * ONE - cy;
            for (x = 0; x < w; x++) begin
                dx = longint'(x) * ONE - cx;
                d2 = dy * dy + dx * dx;
                in_circle = (d2 <= r2);
                if (r1 < 0) begin
                    rim = 1'b1;
                end else if (r1 == 0) begin
                    rim = (d2 > 0);
                end else begin
                    rim = (d2 > r12);
                end
                if (in_circle && (shape == SHAPE_FILLED || rim)) begin
                    pixels[y * MAX_WIDTH + x] = paint;
                end
            end
        end
    endtask

    task automatic predict_request();
        t_frame_answer ans;
        int unsigned   w;
        int unsigned   h;
        longint        cx;
        longint        cy;
        longint        rad;
        w   = used_dim(width_reg, MAX_WIDTH);
        h   = used_dim(height_reg, MAX_HEIGHT);
        cx  = i_req.center_x;
        cy  = i_req.center_y;
        rad = i_req.circle_radius;
        ans.status = frame_bad ? STAT_BAD_FRAME : STAT_OK;
        ans.pixel  = '0;
        case (i_req.req_type)
            REQ_CLEAR: begin
                for (int i = 0; i < PIX_DEPTH; i++) pixels[i] = bg_reg;
                frame_bad  = 1'b0;
                ans.status = STAT_OK;
            end
            REQ_DRAW: begin
                if (frame_bad) begin
                    ans.status = STAT_BAD_FRAME;
                end else if (rad <= 0 || (i_req.shape_char != SHAPE_OUTLINE &&
                                          i_req.shape_char != SHAPE_FILLED)) begin
                    frame_bad  = 1'b1;
                    ans.status = STAT_REJECT;
                end else begin
                    paint_circle(i_req.shape_char, cx, cy, rad, i_req.paint_byte, w, h);
                    ans.status = STAT_OK;
                    o_drawn++;
                end
            end
            REQ_READ: begin
                if (i_req.read_col < w && i_req.read_row < h) begin
                    ans.pixel = pixels[int'(i_req.read_row) * MAX_WIDTH + int'(i_req.read_col)];
                end
            end
            default: ;
        endcase
        answers_q.push_back(ans);
    endtask

    always @(posedge i_clk) begin
        t_frame_answer ans;
        if (!i_rst_n) begin
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            bg_reg     = '0;
            frame_bad  = 1'b0;
            answers_q.delete();
            o_errors   = 0;
            o_checked  = 0;
            o_drawn    = 0;
        end else begin
            // Retire first: a result never belongs to a transaction of this same edge
            if (i_res.valid && i_res.ready) begin
                if (answers_q.size() == 0) begin
                    report_mismatch($sformatf("result status %0d pixel 0x%02h with nothing awaited",
                                              i_res.status, i_res.pixel_value));
                end else begin
                    ans = answers_q.pop_front();
                    if (i_res.status !== ans.status) begin
                        report_mismatch($sformatf("result %0d status got %0d want %0d",
                                                  o_checked, i_res.status, ans.status));
                    end
                    if (i_res.pixel_value !== ans.pixel) begin
                        report_mismatch($sformatf("result %0d pixel got 0x%02h want 0x%02h",
                                                  o_checked, i_res.pixel_value, ans.pixel));
                    end
                    o_checked++;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.wr_index)
                    CFG_FRAME_WIDTH:  width_reg  = i_cfg.wr_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg.wr_data;
                    CFG_BACKGROUND:   bg_reg     = i_cfg.wr_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) predict_request();
        end
        o_pending = answers_q.size();
    end

endmodule

// ----- tb/circle_raster_fill_outline_tb.sv -----
// Top of the circle framebuffer testbench: clock, reset, request and register stimulus.
// Verdict comes from the checker's mismatch count. Depends on crfo_pkg, crfo_if.sv,
// the block and circle_raster_fill_outline_checker.
`timescale 1ns / 100ps

module circle_raster_fill_outline_tb;
    import crfo_pkg::*;

    localparam logic [REQ_W-1:0]  REQ_UNKNOWN   = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam int                MAX_GAP       = 12;
    localparam int                HOLD_CYCLES   = 400;
    localparam int                SETTLE_CYCLES = 8;
    localparam int                EPISODES      = 7;
    localparam int                EPISODE_ITEMS = 12;
    localparam int                HOLD_EPISODE  = 3;
    localparam int                BURST_EPISODE = 5;
    localparam int                WIDE_EPISODE  = 4;
    // Slowest run is about 9 full-store passes; allow several times that
    localparam int                CYCLE_LIMIT   = 3_000_000;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [BYTE_W-1:0]         shape;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] rad;
        logic [BYTE_W-1:0]         paint;
        logic [BYTE_W-1:0]         col;
        logic [BYTE_W-1:0]         row;
    } t_request;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    crfo_req_if req_ch();
    crfo_res_if res_ch();
    crfo_cfg_if cfg_ch();

    int mismatches;
    int pending;
    int answered;
    int painted;
    int cycle_count = 0;
    int offered     = 0;
    int reg_writes  = 0;
    bit hold_off_req = 1'b0;
    bit burst_mode   = 1'b0;

    circle_raster_fill_outline dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    circle_raster_fill_outline_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (mismatches),
        .o_pending (pending),
        .o_checked (answered),
        .o_drawn   (painted)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
            $display("circle_raster_fill_outline_tb: done, errors");
            $finish;
        end
    end

    // Result side: random ready gaps, plus one long hold-off on request
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready = 1'b0;
                hold_off_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!burst_mode) begin
                gap = $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    res_ch.ready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            res_ch.ready = 1'b1;
            do begin
                @(posedge i_clk);
            end while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    function automatic t_request random_request(logic [REQ_W-1:0] kind);
        t_request rq;
        rq.kind  = kind;
        rq.shape = BYTE_W'($urandom);
        rq.cx    = COORD_W'($urandom);
        rq.cy    = COORD_W'($urandom);
        rq.rad   = COORD_W'($urandom);
        rq.paint = BYTE_W'($urandom);
        rq.col   = BYTE_W'($urandom);
        rq.row   = BYTE_W'($urandom);
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic offer_request(t_request rq);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type      = rq.kind;
        req_ch.shape_char    = rq.shape;
        req_ch.center_x      = rq.cx;
        req_ch.center_y      = rq.cy;
        req_ch.circle_radius = rq.rad;
        req_ch.paint_byte    = rq.paint;
        req_ch.read_col      = rq.col;
        req_ch.read_row      = rq.row;
        req_ch.valid         = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        @(negedge i_clk);
        offered++;
    endtask

    task automatic clear_frame();
        offer_request(random_request(REQ_CLEAR));
    endtask

    task automatic read_pixel(int col, int row);
        t_request rq;
        rq     = random_request(REQ_READ);
        rq.col = BYTE_W'(col);
        rq.row = BYTE_W'(row);
        offer_request(rq);
    endtask

    task automatic draw_circle(logic [BYTE_W-1:0] shape, int cx, int cy, int rad,
                               logic [BYTE_W-1:0] paint);
        t_request rq;
        rq       = random_request(REQ_DRAW);
        rq.shape = shape;
        rq.cx    = COORD_W'(cx);
        rq.cy    = COORD_W'(cy);
        rq.rad   = COORD_W'(rad);
        rq.paint = paint;
        offer_request(rq);
    endtask

    // Drop valid and wait for every awaited result before touching registers
    task automatic settle();
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CIDX_W-1:0] idx, int data);
        cfg_ch.wr_index = idx;
        cfg_ch.wr_data  = DIM_W'(data);
        cfg_ch.valid    = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        reg_writes++;
    endtask

    initial begin
        t_request rq;
        int       w;
        int       h;
        int       span;
        int       pick;
        int       rad;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = '0;
        req_ch.shape_char    = '0;
        req_ch.center_x      = '0;
        req_ch.center_y      = '0;
        req_ch.circle_radius = '0;
        req_ch.paint_byte    = '0;
        req_ch.read_col      = '0;
        req_ch.read_row      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.wr_index      = '0;
        cfg_ch.wr_data       = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset sizes and background; clear first so no unwritten pixel is ever read
        clear_frame();
        read_pixel(0, 0);
        read_pixel(255, 255);
        draw_circle(SHAPE_FILLED, 128 * ONE, 128 * ONE, 40 * ONE, 8'hA5);
        read_pixel(128, 128);
        read_pixel(168, 128);
        read_pixel(169, 128);

        // Saturating sizes: width 0 acts as 1, height 300 as 256
        settle();
        write_register(CFG_FRAME_WIDTH, 0);
        write_register(CFG_FRAME_HEIGHT, 300);
        write_register(CFG_BACKGROUND, 'h1FF);
        write_register(CFG_UNUSED, 'h155);
        clear_frame();
        read_pixel(0, 5);
        read_pixel(1, 0);
        draw_circle(SHAPE_OUTLINE, 0, 100 * ONE, 1, 8'h11);
        read_pixel(0, 100);
        draw_circle(SHAPE_FILLED, -524288, 524287, 524287, 8'h5A);

        // Width 511 acts as 256, height 0 as 1; the clear above filled the whole store
        settle();
        write_register(CFG_FRAME_WIDTH, 'h1FF);
        write_register(CFG_FRAME_HEIGHT, 0);
        write_register(CFG_BACKGROUND, 0);
        read_pixel(200, 0);
        draw_circle(SHAPE_OUTLINE, 5 * ONE, 0, ONE, 8'h77);
        read_pixel(5, 0);
        read_pixel(6, 0);
        draw_circle(8'h58, 3 * ONE, 0, 2 * ONE, 8'h01);
        draw_circle(SHAPE_FILLED, 3 * ONE, 0, 2 * ONE, 8'h02);
        offer_request(random_request(REQ_UNKNOWN));
        read_pixel(6, 0);
        clear_frame();
        draw_circle(SHAPE_FILLED, 3 * ONE, 0, 0, 8'h03);
        clear_frame();
        draw_circle(SHAPE_OUTLINE, 3 * ONE, 0, -524288, 8'h04);

        for (int ep = 0; ep < EPISODES; ep++) begin
            settle();
            w = (ep == WIDE_EPISODE) ? MAX_WIDTH : $urandom_range(1, 24);
            h = (ep == WIDE_EPISODE) ? $urandom_range(1, 3) : $urandom_range(1, 24);
            write_register(CFG_FRAME_WIDTH, w);
            write_register(CFG_FRAME_HEIGHT, h);
            write_register(CFG_BACKGROUND, $urandom_range(0, 511));
            span = ((w > h) ? w : h) * ONE;
            burst_mode = (ep == BURST_EPISODE);
            // Hold results back while reads keep coming, so the block backs up
            if (ep == HOLD_EPISODE) hold_off_req = 1'b1;
            if (ep % 2 == 0) clear_frame();
            for (int n = 0; n < EPISODE_ITEMS; n++) begin
                pick = (ep == HOLD_EPISODE && n < 5) ? 0 : $urandom_range(0, 99);
                if (pick < 40) begin
                    if ($urandom_range(0, 3) == 0) begin
                        read_pixel($urandom_range(0, 255), $urandom_range(0, 255));
                    end else begin
                        read_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
                    end
                end else if (pick < 80 || n < 8) begin
                    rad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span)
                                                      : $urandom_range(1, 4 * ONE);
                    draw_circle($urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE,
                                $urandom_range(0, (w + 4) * ONE) - 2 * ONE,
                                $urandom_range(0, (h + 4) * ONE) - 2 * ONE,
                                rad, BYTE_W'($urandom));
                end else if (pick < 93) begin
                    // Full-range fields: mostly far away or rejected
                    rq = random_request(REQ_DRAW);
                    if ($urandom_range(0, 1)) begin
                        rq.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                    end
                    offer_request(rq);
                end else begin
                    offer_request(random_request(REQ_UNKNOWN));
                end
            end
        end
        burst_mode = 1'b0;

        settle();
        $display("summary: %0d requests sent, %0d results checked, %0d circles painted",
                 offered, answered, painted);
        $display("summary: %0d register writes, frames 1x1 to 256x256, %0d-cycle result hold-off",
                 reg_writes, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("circle_raster_fill_outline_tb: done, clean");
        end else begin
            $display("circle_raster_fill_outline_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/crfo_pkg.sv
src/crfo_if.sv
src/circle_raster_fill_outline.sv
tb/circle_raster_fill_outline_checker.sv
tb/circle_raster_fill_outline_tb.sv
